>>> src/clamped_pid_controller_assert.svh
// ----------------------------------------------------------------------------
// clamped_pid_controller_assert.svh
// Assertion macros used by the clamped PID controller RTL.
// ----------------------------------------------------------------------------
`ifndef CLAMPED_PID_CONTROLLER_ASSERT_SVH
`define CLAMPED_PID_CONTROLLER_ASSERT_SVH

// Check a consequent in the same cycle as its antecedent.
`define CPID_ASSERT_SAME(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequent in the cycle after its antecedent.
`define CPID_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/cpid_pkg.sv
// ----------------------------------------------------------------------------
// cpid_pkg
// Widths, register indexes, command codes and shared types of the clamped
// PID controller.
// ----------------------------------------------------------------------------
package cpid_pkg;

   // Fixed-point format of the gains and of the integral accumulator
   localparam int FRAC_BITS = 8;

   // Field widths
   localparam int DATA_W    = 16;
   localparam int GAIN_W    = 16;
   localparam int PER_W     = 10;
   localparam int LIM_W     = 16;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 16;

   // Derived datapath widths
   localparam int ERR_W     = DATA_W + 1;
   localparam int DIFF_W    = ERR_W + 1;
   localparam int TERM_W    = LIM_W + 1;
   localparam int SUM_W     = TERM_W + 2;
   localparam int MUL_A_W   = GAIN_W + DIFF_W;
   localparam int MUL_B_W   = DIFF_W;
   localparam int PROD_W    = MUL_A_W + PER_W + 1;
   localparam int DIV_W     = PROD_W - 1;
   localparam int DIV_RADIX_BITS = 2;
   localparam int DIV_STEPS = DIV_W / DIV_RADIX_BITS;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);
   localparam int INC_W     = ERR_W + GAIN_W;
   localparam int ACC_W     = ERR_W + FRAC_BITS;
   localparam int ACC_SUM_W = INC_W + 2;

   // Milliseconds per second, used in integral and derivative scaling
   localparam logic [PER_W-1:0] MS_PER_S = 10'd1000;

   // Reset values of the control registers
   localparam logic [GAIN_W-1:0] RST_GAIN       = 16'd0;
   localparam logic [PER_W-1:0]  RST_PERIOD     = 10'd10;
   localparam logic [LIM_W-1:0]  RST_TERM_LIMIT = 16'd99;
   localparam logic [DATA_W-1:0] RST_DRIVE_MAX  = 16'd99;
   localparam logic [DATA_W-1:0] RST_DRIVE_MIN  = 16'd0;

   // Control register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TERM_LIMIT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_MAX  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_DRIVE_MIN  = 3'd6;

   // Shared multiplier operations
   typedef logic [2:0] mul_op_type;
   localparam mul_op_type MUL_NONE = 3'd0;
   localparam mul_op_type MUL_P    = 3'd1;
   localparam mul_op_type MUL_I1   = 3'd2;
   localparam mul_op_type MUL_I2   = 3'd3;
   localparam mul_op_type MUL_D1   = 3'd4;
   localparam mul_op_type MUL_D2   = 3'd5;

   typedef struct packed {
      logic signed [GAIN_W-1:0] gain_p;
      logic signed [GAIN_W-1:0] gain_i;
      logic signed [GAIN_W-1:0] gain_d;
      logic [PER_W-1:0]         period_ms;
      logic [LIM_W-1:0]         term_limit;
      logic [DATA_W-1:0]        drive_max;
      logic [DATA_W-1:0]        drive_min;
   } cfg_type;

   typedef struct packed {
      logic       load;
      mul_op_type mul_op;
      logic       div_start;
      logic       div_sel_d;
      logic       p_store;
      logic       i_store;
      logic       d_store;
      logic       out_load;
   } cmd_type;

   typedef struct packed {
      logic div_busy;
   } status_type;

endpackage

>>> src/cpid_ctrl.sv
// ----------------------------------------------------------------------------
// cpid_ctrl
// Sequencer of the clamped PID controller: steps the shared multiplier and
// divider through one sample and owns the handshake state.
// ----------------------------------------------------------------------------
module cpid_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  cpid_pkg::status_type status,
   output cpid_pkg::cmd_type    cmd
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_MUL_P  = 4'd1;
   localparam logic [3:0] ST_MUL_I1 = 4'd2;
   localparam logic [3:0] ST_MUL_I2 = 4'd3;
   localparam logic [3:0] ST_DIV_I  = 4'd4;
   localparam logic [3:0] ST_MUL_D2 = 4'd5;
   localparam logic [3:0] ST_WAIT_I = 4'd6;
   localparam logic [3:0] ST_WAIT_D = 4'd7;
   localparam logic [3:0] ST_FINISH = 4'd8;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   // Output register can take a new result
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   // Sequence one sample
   always_comb begin
      cmd        = '0;
      cmd.mul_op = cpid_pkg::MUL_NONE;
      state_in   = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL_P;
            end
         end
         ST_MUL_P: begin
            cmd.mul_op = cpid_pkg::MUL_P;
            state_in   = ST_MUL_I1;
         end
         ST_MUL_I1: begin
            cmd.mul_op  = cpid_pkg::MUL_I1;
            cmd.p_store = 1'b1;
            state_in    = ST_MUL_I2;
         end
         ST_MUL_I2: begin
            cmd.mul_op = cpid_pkg::MUL_I2;
            state_in   = ST_DIV_I;
         end
         ST_DIV_I: begin
            // Launch the integral divide and start the derivative product
            cmd.div_start = 1'b1;
            cmd.mul_op    = cpid_pkg::MUL_D1;
            state_in      = ST_MUL_D2;
         end
         ST_MUL_D2: begin
            cmd.mul_op = cpid_pkg::MUL_D2;
            state_in   = ST_WAIT_I;
         end
         ST_WAIT_I: begin
            if (!status.div_busy) begin
               cmd.i_store   = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_sel_d = 1'b1;
               state_in      = ST_WAIT_D;
            end
         end
         ST_WAIT_D: begin
            if (!status.div_busy) begin
               cmd.d_store = 1'b1;
               state_in    = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // Hold until the previous result has left
            if (out_free) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Track the output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

>>> src/cpid_datapath.sv
// ----------------------------------------------------------------------------
// cpid_datapath
// Datapath of the clamped PID controller: error capture, one shared
// multiplier, a radix-4 restoring divider, term clamps and the output sum.
// ----------------------------------------------------------------------------
module cpid_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  cpid_pkg::cfg_type           cfg,
   input  cpid_pkg::cmd_type           cmd,
   output cpid_pkg::status_type        status,
   input  logic [cpid_pkg::DATA_W-1:0] req_target,
   input  logic [cpid_pkg::DATA_W-1:0] req_measured,
   output logic [cpid_pkg::DATA_W-1:0] rsp_drive
);

   localparam int ERR_W     = cpid_pkg::ERR_W;
   localparam int DIFF_W    = cpid_pkg::DIFF_W;
   localparam int TERM_W    = cpid_pkg::TERM_W;
   localparam int LIM_W     = cpid_pkg::LIM_W;
   localparam int PER_W     = cpid_pkg::PER_W;
   localparam int PROD_W    = cpid_pkg::PROD_W;
   localparam int DIV_W     = cpid_pkg::DIV_W;
   localparam int ACC_W     = cpid_pkg::ACC_W;
   localparam int ACC_SUM_W = cpid_pkg::ACC_SUM_W;
   localparam int SUM_W     = cpid_pkg::SUM_W;
   localparam int DATA_W    = cpid_pkg::DATA_W;
   localparam int GAIN_W    = cpid_pkg::GAIN_W;
   localparam int MUL_A_W   = cpid_pkg::MUL_A_W;
   localparam int MUL_B_W   = cpid_pkg::MUL_B_W;
   localparam int CNT_W     = cpid_pkg::DIV_CNT_W;
   localparam int FRAC      = cpid_pkg::FRAC_BITS;

   // Limit a magnitude to the term limit
   function automatic logic [LIM_W-1:0] clamp_mag(input logic [PROD_W-1:0] mag,
                                                  input logic [LIM_W-1:0]  lim);
      logic [LIM_W-1:0] res;
      if (mag > PROD_W'(lim)) begin
         res = lim;
      end else begin
         res = mag[LIM_W-1:0];
      end
      return res;
   endfunction

   // Reapply the sign to a clamped magnitude
   function automatic logic signed [TERM_W-1:0] signed_term(input logic [LIM_W-1:0] mag,
                                                            input logic neg);
      logic signed [TERM_W-1:0] res;
      res = $signed({1'b0, mag});
      if (neg) begin
         res = -res;
      end
      return res;
   endfunction

   // Sample registers
   logic signed [ERR_W-1:0]  error_ff, error_in, prev_error_ff, prev_error_in;
   logic signed [DIFF_W-1:0] diff_ff, diff_in;
   logic signed [ERR_W-1:0]  error_new;
   logic signed [DIFF_W-1:0] diff_new;

   // Multiplier
   logic signed [MUL_A_W-1:0]         mul_a;
   logic signed [MUL_B_W-1:0]         mul_b;
   logic signed [MUL_A_W+MUL_B_W-1:0] mul_full;
   logic signed [PROD_W-1:0]          prod_ff, prod_in;
   logic                              prod_neg;
   logic [PROD_W-1:0]                 prod_mag, prod_shift;
   logic [PER_W-1:0]                  per_eff;

   // Divider
   logic [DIV_W-1:0] quo_ff, quo_in, step_quo;
   logic [PER_W-1:0] rem_ff, rem_in, step_rem;
   logic [PER_W-1:0] divisor_ff, divisor_in;
   logic [PER_W:0]   trial;
   logic [CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic             div_busy_ff, div_busy_in;
   logic             div_neg_ff, div_neg_in;

   // Terms and accumulator
   logic signed [TERM_W-1:0]    p_term_ff, p_term_in, d_term_ff, d_term_in, i_term;
   logic signed [ACC_W-1:0]     acc_ff, acc_in;
   logic [ACC_W-1:0]            acc_mag;
   logic signed [ACC_SUM_W-1:0] inc_val, acc_sum, acc_lim, acc_clamped;

   // Output sum
   logic signed [SUM_W-1:0] total, upper, lower, drive_max_s, drive_min_s;
   logic [DATA_W-1:0]       drive_ff, drive_in;

   // Form the error and its change from the last sample
   assign error_new = $signed({1'b0, req_target}) - $signed({1'b0, req_measured});
   assign diff_new  = $signed({error_new[ERR_W-1], error_new})
                    - $signed({prev_error_ff[ERR_W-1], prev_error_ff});

   always_comb begin
      error_in      = error_ff;
      diff_in       = diff_ff;
      prev_error_in = prev_error_ff;
      if (cmd.load) begin
         error_in      = error_new;
         diff_in       = diff_new;
         prev_error_in = error_new;
      end
   end

   // A zero period counts as one
   assign per_eff = (cfg.period_ms == '0) ? PER_W'(1) : cfg.period_ms;

   // Select the multiplier operands
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.mul_op)
         cpid_pkg::MUL_P: begin
            mul_a = {{(MUL_A_W-GAIN_W){cfg.gain_p[GAIN_W-1]}}, cfg.gain_p};
            mul_b = {error_ff[ERR_W-1], error_ff};
         end
         cpid_pkg::MUL_I1: begin
            mul_a = {{(MUL_A_W-GAIN_W){cfg.gain_i[GAIN_W-1]}}, cfg.gain_i};
            mul_b = {error_ff[ERR_W-1], error_ff};
         end
         cpid_pkg::MUL_I2: begin
            mul_a = prod_ff[MUL_A_W-1:0];
            mul_b = {{(MUL_B_W-PER_W){1'b0}}, per_eff};
         end
         cpid_pkg::MUL_D1: begin
            mul_a = {{(MUL_A_W-GAIN_W){cfg.gain_d[GAIN_W-1]}}, cfg.gain_d};
            mul_b = diff_ff;
         end
         cpid_pkg::MUL_D2: begin
            mul_a = prod_ff[MUL_A_W-1:0];
            mul_b = {{(MUL_B_W-PER_W){1'b0}}, cpid_pkg::MS_PER_S};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_full = mul_a * mul_b;
   assign prod_in  = (cmd.mul_op != cpid_pkg::MUL_NONE) ? mul_full[PROD_W-1:0] : prod_ff;

   // Split the product into sign and magnitude
   assign prod_neg   = prod_ff[PROD_W-1];
   assign prod_mag   = prod_neg ? PROD_W'(-prod_ff) : prod_ff;
   assign prod_shift = prod_mag >> FRAC;

   // Two restoring divide steps per cycle
   always_comb begin
      step_rem = rem_ff;
      step_quo = quo_ff;
      trial    = '0;
      for (int k = 0; k < cpid_pkg::DIV_RADIX_BITS; k++) begin
         trial    = {step_rem, step_quo[DIV_W-1]};
         step_quo = {step_quo[DIV_W-2:0], 1'b0};
         if (trial >= {1'b0, divisor_ff}) begin
            trial       = trial - {1'b0, divisor_ff};
            step_quo[0] = 1'b1;
         end
         step_rem = trial[PER_W-1:0];
      end
   end

   // Load or advance the divider
   always_comb begin
      quo_in      = quo_ff;
      rem_in      = rem_ff;
      divisor_in  = divisor_ff;
      div_neg_in  = div_neg_ff;
      div_cnt_in  = div_cnt_ff;
      div_busy_in = div_busy_ff;
      if (cmd.div_start) begin
         quo_in      = cmd.div_sel_d ? prod_shift[DIV_W-1:0] : prod_mag[DIV_W-1:0];
         divisor_in  = cmd.div_sel_d ? per_eff : cpid_pkg::MS_PER_S;
         rem_in      = '0;
         div_neg_in  = prod_neg;
         div_cnt_in  = CNT_W'(cpid_pkg::DIV_STEPS);
         div_busy_in = 1'b1;
      end else if (div_busy_ff) begin
         quo_in      = step_quo;
         rem_in      = step_rem;
         div_cnt_in  = div_cnt_ff - CNT_W'(1);
         div_busy_in = (div_cnt_ff != CNT_W'(1));
      end
   end

   assign status.div_busy = div_busy_ff;

   // Update the integral and clamp it to the scaled term limit
   always_comb begin
      inc_val = $signed({2'b00, quo_ff[cpid_pkg::INC_W-1:0]});
      if (div_neg_ff) begin
         inc_val = -inc_val;
      end
      acc_sum = $signed({{(ACC_SUM_W-ACC_W){acc_ff[ACC_W-1]}}, acc_ff}) + inc_val;
      acc_lim = $signed({{(ACC_SUM_W-LIM_W-FRAC){1'b0}}, cfg.term_limit, {FRAC{1'b0}}});
      if (acc_sum > acc_lim) begin
         acc_clamped = acc_lim;
      end else if (acc_sum < -acc_lim) begin
         acc_clamped = -acc_lim;
      end else begin
         acc_clamped = acc_sum;
      end
      acc_in = cmd.i_store ? acc_clamped[ACC_W-1:0] : acc_ff;
   end

   // Integral term, truncated toward zero
   assign acc_mag = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : acc_ff;
   assign i_term  = signed_term(acc_mag[FRAC+LIM_W-1:FRAC], acc_ff[ACC_W-1]);

   // Clamp the proportional and derivative terms
   assign p_term_in = cmd.p_store ? signed_term(clamp_mag(prod_shift, cfg.term_limit), prod_neg)
                                  : p_term_ff;
   assign d_term_in = cmd.d_store ? signed_term(clamp_mag({1'b0, quo_ff}, cfg.term_limit),
                                                div_neg_ff)
                                  : d_term_ff;

   // Sum the terms, clamp to the upper bound and then the lower one
   always_comb begin
      drive_max_s = $signed({{(SUM_W-DATA_W){1'b0}}, cfg.drive_max});
      drive_min_s = $signed({{(SUM_W-DATA_W){1'b0}}, cfg.drive_min});
      total = SUM_W'(p_term_ff) + SUM_W'(i_term) + SUM_W'(d_term_ff);
      upper = (total > drive_max_s) ? drive_max_s : total;
      lower = (upper < drive_min_s) ? drive_min_s : upper;
      drive_in = cmd.out_load ? lower[DATA_W-1:0] : drive_ff;
   end

   assign rsp_drive = drive_ff;

   // Controller state held across samples
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_error_ff <= '0;
         acc_ff        <= '0;
         div_busy_ff   <= 1'b0;
         div_cnt_ff    <= '0;
      end else begin
         prev_error_ff <= prev_error_in;
         acc_ff        <= acc_in;
         div_busy_ff   <= div_busy_in;
         div_cnt_ff    <= div_cnt_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      error_ff   <= error_in;
      diff_ff    <= diff_in;
      prod_ff    <= prod_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
      div_neg_ff <= div_neg_in;
      p_term_ff  <= p_term_in;
      d_term_ff  <= d_term_in;
      drive_ff   <= drive_in;
   end

endmodule

>>> src/clamped_pid_controller.sv
// ----------------------------------------------------------------------------
// clamped_pid_controller
// Fixed-point PID controller with clamped P, I and D terms and drive limits.
//
// A sample (req_target, req_measured) is taken when req_valid is high and
// req_stall is low. One drive value comes back on rsp_drive, qualified by
// rsp_valid, and leaves when rsp_stall is low.
// Each sample takes two passes of the shared radix-4 divider (the integral
// scaling by 1000 and the derivative scaling by the period), with the P and
// integral multiplies ahead of the first pass, the derivative multiplies
// beside it, and stores of the integral, the derivative and the drive.
// req_stall is high from acceptance until the result is in the output
// register. A finished result waits there while the next sample is worked
// on; if that one finishes before the receiver takes the first, the block
// holds it and keeps req_stall high.
// Registers are written through csr_write, csr_index and csr_data; the user
// must write them only while no transaction is in flight, which the block
// itself leaves unchecked. Index 7 is ignored.
// Synchronous reset restores the register defaults and clears the integral,
// the previous error and both handshakes.
// ----------------------------------------------------------------------------
`include "clamped_pid_controller_assert.svh"

module clamped_pid_controller (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [cpid_pkg::DATA_W-1:0]     req_target,
   input  logic [cpid_pkg::DATA_W-1:0]     req_measured,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [cpid_pkg::DATA_W-1:0]     rsp_drive,
   input  logic                            csr_write,
   input  logic [cpid_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cpid_pkg::CSR_DATA_W-1:0] csr_data
);

   cpid_pkg::cfg_type    cfg_ff;
   cpid_pkg::cfg_type    cfg_in;
   cpid_pkg::cmd_type    cmd;
   cpid_pkg::status_type status;

   // Drive limits from the previous cycle, for the drive range checks
   logic [cpid_pkg::DATA_W-1:0] chk_min_ff, chk_max_ff;
   logic                        load_ordered, load_crossed;
   logic                        drive_in_lim, drive_at_min;

   // Decode register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            cpid_pkg::CSR_GAIN_P:     cfg_in.gain_p     = csr_data;
            cpid_pkg::CSR_GAIN_I:     cfg_in.gain_i     = csr_data;
            cpid_pkg::CSR_GAIN_D:     cfg_in.gain_d     = csr_data;
            cpid_pkg::CSR_PERIOD:     cfg_in.period_ms  = csr_data[cpid_pkg::PER_W-1:0];
            cpid_pkg::CSR_TERM_LIMIT: cfg_in.term_limit = csr_data;
            cpid_pkg::CSR_DRIVE_MAX:  cfg_in.drive_max  = csr_data;
            cpid_pkg::CSR_DRIVE_MIN:  cfg_in.drive_min  = csr_data;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain_p     <= cpid_pkg::RST_GAIN;
         cfg_ff.gain_i     <= cpid_pkg::RST_GAIN;
         cfg_ff.gain_d     <= cpid_pkg::RST_GAIN;
         cfg_ff.period_ms  <= cpid_pkg::RST_PERIOD;
         cfg_ff.term_limit <= cpid_pkg::RST_TERM_LIMIT;
         cfg_ff.drive_max  <= cpid_pkg::RST_DRIVE_MAX;
         cfg_ff.drive_min  <= cpid_pkg::RST_DRIVE_MIN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cpid_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   cpid_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg_ff),
      .cmd          (cmd),
      .status       (status),
      .req_target   (req_target),
      .req_measured (req_measured),
      .rsp_drive    (rsp_drive)
   );

   // Hold the limits seen at the output load for the next-cycle checks
   always_ff @(posedge clock) begin
      chk_min_ff <= cfg_ff.drive_min;
      chk_max_ff <= cfg_ff.drive_max;
   end

   assign load_ordered = cmd.out_load && (cfg_ff.drive_min <= cfg_ff.drive_max);
   assign load_crossed = cmd.out_load && (cfg_ff.drive_min > cfg_ff.drive_max);
   assign drive_in_lim = (rsp_drive >= chk_min_ff) && (rsp_drive <= chk_max_ff);
   assign drive_at_min = (rsp_drive == chk_min_ff);

   // Divider is never relaunched mid-divide
   `CPID_ASSERT_SAME(a_div_start_idle, cmd.div_start, !status.div_busy, "divider restarted while busy")

   // A waiting result is never overwritten
   `CPID_ASSERT_SAME(a_out_no_overwrite, cmd.out_load, !rsp_valid || !rsp_stall, "result overwritten")

   // With ordered limits the drive lands inside them
   `CPID_ASSERT_NEXT(a_drive_in_range, load_ordered, drive_in_lim, "drive outside limits")

   // With crossed limits the lower limit wins
   `CPID_ASSERT_NEXT(a_drive_crossed, load_crossed, drive_at_min, "crossed limits not resolved")

endmodule

>>> test/tb_clamped_pid_controller.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_clamped_pid_controller
// Self-checking regression of the clamped PID controller.
//
// A clocked driver feeds samples from a queue that the stimulus process fills
// phase by phase. A clocked monitor compares every drive value against a
// fixed-point PID predictor that runs at sample acceptance. Both sides idle
// in random bursts. Register settings change only while the block is idle,
// and cover extreme gains, zero and oversized periods, zero term limits and
// crossed drive clamps.
// ----------------------------------------------------------------------------
module tb_clamped_pid_controller;
   import cpid_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 3'd7;
   localparam int CYCLE_LIMIT = 500000;
   localparam int RANDOM_PHASES = 12;
   localparam int SAMPLES_PER_PHASE = 75;

   typedef struct packed {
      logic [DATA_W-1:0] target;
      logic [DATA_W-1:0] measured;
   } sample_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [DATA_W-1:0]     req_target = '0;
   logic [DATA_W-1:0]     req_measured = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [DATA_W-1:0]     rsp_drive;
   logic                  csr_write = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Predictor state and register copy
   cfg_type ctl_regs = '{gain_p: RST_GAIN, gain_i: RST_GAIN, gain_d: RST_GAIN,
                         period_ms: RST_PERIOD, term_limit: RST_TERM_LIMIT,
                         drive_max: RST_DRIVE_MAX, drive_min: RST_DRIVE_MIN};
   longint integ_acc = 0;
   longint last_error = 0;

   sample_type        sample_q[$];
   sample_type        next_sample;
   logic [DATA_W-1:0] drive_expect_q[$];
   logic [DATA_W-1:0] drive_want;

   int  items_queued = 0;
   int  items_accepted = 0;
   int  drives_checked = 0;
   int  error_count = 0;
   int  settings_count = 0;
   int  cycle_count = 0;
   int  send_gap = 0;
   int  recv_gap = 0;
   bit  quiet = 1'b0;

   clamped_pid_controller dut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_target   (req_target),
      .req_measured (req_measured),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_drive    (rsp_drive),
      .csr_write    (csr_write),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   always #5 clock = ~clock;

   // Clamp to a symmetric magnitude
   function automatic longint clamp_mag(input longint v, input longint lim);
      longint r;
      r = v;
      if (r > lim) r = lim;
      if (r < -lim) r = -lim;
      return r;
   endfunction

   // Advance the PID state by one sample and return its drive
   function automatic logic [DATA_W-1:0] next_drive(input logic [DATA_W-1:0] tgt,
                                                     input logic [DATA_W-1:0] meas);
      longint one, per, err, lim, p_t, i_t, d_t, total;
      one = longint'(1) << FRAC_BITS;
      per = (ctl_regs.period_ms == '0) ? longint'(1) : longint'(ctl_regs.period_ms);
      err = longint'(tgt) - longint'(meas);
      lim = longint'(ctl_regs.term_limit);
      p_t = clamp_mag((longint'($signed(ctl_regs.gain_p)) * err) / one, lim);
      integ_acc = clamp_mag(integ_acc +
                            (err * longint'($signed(ctl_regs.gain_i)) * per) / 1000,
                            lim * one);
      i_t = integ_acc / one;
      d_t = clamp_mag((longint'($signed(ctl_regs.gain_d)) * (err - last_error) * 1000)
                      / (per * one), lim);
      total = p_t + i_t + d_t;
      if (total > longint'(ctl_regs.drive_max)) total = longint'(ctl_regs.drive_max);
      if (total < longint'(ctl_regs.drive_min)) total = longint'(ctl_regs.drive_min);
      last_error = err;
      return total[DATA_W-1:0];
   endfunction

   // Write one control register and mirror it in the predictor copy
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      case (idx)
         CSR_GAIN_P:     ctl_regs.gain_p = data;
         CSR_GAIN_I:     ctl_regs.gain_i = data;
         CSR_GAIN_D:     ctl_regs.gain_d = data;
         CSR_PERIOD:     ctl_regs.period_ms = data[PER_W-1:0];
         CSR_TERM_LIMIT: ctl_regs.term_limit = data;
         CSR_DRIVE_MAX:  ctl_regs.drive_max = data;
         CSR_DRIVE_MIN:  ctl_regs.drive_min = data;
         default: ;
      endcase
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   task automatic queue_sample(input logic [DATA_W-1:0] tgt, input logic [DATA_W-1:0] meas);
      sample_q.push_back('{target: tgt, measured: meas});
      items_queued++;
   endtask

   // Hold off until every queued sample has produced its checked drive
   task automatic wait_idle();
      do @(posedge clock);
      while (items_accepted != items_queued || drive_expect_q.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   function automatic logic [GAIN_W-1:0] pick_gain();
      int g;
      case ($urandom_range(0, 9))
         0:       g = 0;
         1:       g = 32767;
         2:       g = -32768;
         3, 4:    g = $urandom_range(0, 65535);
         default: g = int'($urandom_range(0, 1536)) - 768;
      endcase
      return g[GAIN_W-1:0];
   endfunction

   // Pick a random register setting, extremes weighted in
   task automatic randomize_settings();
      logic [PER_W-1:0] per;
      logic [LIM_W-1:0] lim, hi, lo;
      case ($urandom_range(0, 9))
         0:       per = '0;
         1:       per = 10'd1;
         2:       per = 10'd1000;
         3:       per = PER_W'($urandom_range(1001, 1023));
         4:       per = PER_W'($urandom_range(1, 1000));
         default: per = PER_W'($urandom_range(1, 100));
      endcase
      case ($urandom_range(0, 9))
         0:       lim = '0;
         1:       lim = 16'hFFFF;
         2, 3:    lim = LIM_W'($urandom_range(0, 65535));
         default: lim = LIM_W'($urandom_range(1, 2000));
      endcase
      case ($urandom_range(0, 9))
         0:       hi = '0;
         1:       hi = 16'hFFFF;
         2, 3:    hi = LIM_W'($urandom_range(0, 65535));
         default: hi = LIM_W'($urandom_range(0, 3000));
      endcase
      case ($urandom_range(0, 9))
         0, 1, 2, 3: lo = '0;
         4:          lo = 16'hFFFF;
         5:          lo = LIM_W'($urandom_range(0, 65535));
         default:    lo = LIM_W'($urandom_range(0, 500));
      endcase
      write_reg(CSR_GAIN_P, pick_gain());
      write_reg(CSR_GAIN_I, pick_gain());
      write_reg(CSR_GAIN_D, pick_gain());
      // upper data bits are don't-care for the period register
      write_reg(CSR_PERIOD, {6'($urandom_range(0, 63)), per});
      write_reg(CSR_TERM_LIMIT, lim);
      write_reg(CSR_DRIVE_MAX, hi);
      write_reg(CSR_DRIVE_MIN, lo);
      if ($urandom_range(0, 3) == 0)
         write_reg(CSR_UNUSED, CSR_DATA_W'($urandom_range(0, 65535)));
      settings_count++;
   endtask

   // Mostly near-setpoint samples so the terms stay out of saturation
   task automatic queue_random_samples(input int n);
      int tgt, meas, span;
      for (int k = 0; k < n; k++) begin
         tgt = $urandom_range(0, 65535);
         case ($urandom_range(0, 3))
            0:       meas = $urandom_range(0, 65535);
            1:       span = 2000;
            default: span = 64;
         endcase
         if (meas < 0 || k % 4 != 0) begin
            span = ($urandom_range(0, 1) == 0) ? 64 : 2000;
            meas = tgt + int'($urandom_range(0, 2 * span)) - span;
            if (meas < 0) meas = 0;
            if (meas > 65535) meas = 65535;
         end
         queue_sample(tgt[DATA_W-1:0], meas[DATA_W-1:0]);
         meas = -1;
      end
   endtask

   // Driver: retire accepted transactions, hold stalled ones, present the next
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            drive_expect_q.push_back(next_drive(req_target, req_measured));
            items_accepted++;
         end
         if (req_valid && req_stall) begin
            // hold the stalled payload
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (sample_q.size() != 0) begin
            next_sample = sample_q.pop_front();
            req_valid    <= 1'b1;
            req_target   <= next_sample.target;
            req_measured <= next_sample.measured;
            if (!quiet && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 17);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: check each accepted drive against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            drives_checked++;
            if (drive_expect_q.size() == 0) begin
               error_count++;
               $display("%0t: unexpected drive, expected none, actual %0d",
                        $time, rsp_drive);
            end else begin
               drive_want = drive_expect_q.pop_front();
               if (rsp_drive !== drive_want) begin
                  error_count++;
                  $display("%0t: drive mismatch, expected %0d, actual %0d",
                           $time, drive_want, rsp_drive);
               end
            end
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
            if (!quiet && $urandom_range(0, 9) == 0) recv_gap = $urandom_range(1, 17);
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("clamped_pid_controller regression: fail");
         $finish;
      end
   end

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset defaults, field extremes
      queue_sample(16'h0000, 16'h0000);
      queue_sample(16'hFFFF, 16'h0000);
      queue_sample(16'h0000, 16'hFFFF);
      queue_sample(16'hFFFF, 16'hFFFF);
      wait_idle();

      // Largest gains, zero period, widest limits; unused index must not land
      write_reg(CSR_GAIN_P, 16'h7FFF);
      write_reg(CSR_GAIN_I, 16'h7FFF);
      write_reg(CSR_GAIN_D, 16'h8000);
      write_reg(CSR_PERIOD, 16'h0000);
      write_reg(CSR_TERM_LIMIT, 16'hFFFF);
      write_reg(CSR_DRIVE_MAX, 16'hFFFF);
      write_reg(CSR_DRIVE_MIN, 16'h0000);
      write_reg(CSR_UNUSED, 16'hFFFF);
      settings_count++;
      queue_sample(16'hFFFF, 16'h0000);
      queue_sample(16'h0000, 16'hFFFF);
      queue_sample(16'h0000, 16'hFFFF);
      queue_sample(16'd1000, 16'd1000);
      queue_sample(16'hFFFF, 16'h0000);
      wait_idle();

      // Zero term limit, crossed drive clamps, period above 1000
      write_reg(CSR_TERM_LIMIT, 16'h0000);
      write_reg(CSR_DRIVE_MAX, 16'd100);
      write_reg(CSR_DRIVE_MIN, 16'd500);
      write_reg(CSR_PERIOD, 16'hFFFF);
      settings_count++;
      queue_sample(16'hFFFF, 16'h0000);
      queue_sample(16'd300, 16'd200);
      queue_sample(16'h0000, 16'hFFFF);
      wait_idle();

      // Most negative gain, moderate limits, drive pinned high then low
      write_reg(CSR_GAIN_P, 16'h8000);
      write_reg(CSR_GAIN_I, 16'hFFFF);
      write_reg(CSR_GAIN_D, 16'h7FFF);
      write_reg(CSR_PERIOD, 16'd1000);
      write_reg(CSR_TERM_LIMIT, 16'd1000);
      write_reg(CSR_DRIVE_MAX, 16'hFFFF);
      write_reg(CSR_DRIVE_MIN, 16'h0000);
      settings_count++;
      queue_sample(16'h0000, 16'd5);
      queue_sample(16'd5, 16'h0000);
      queue_sample(16'd40000, 16'd40000);
      queue_sample(16'h0000, 16'hFFFF);
      wait_idle();

      // Random settings and samples; the final phase runs without idling
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == RANDOM_PHASES - 1) quiet = 1'b1;
         randomize_settings();
         queue_random_samples(SAMPLES_PER_PHASE);
         wait_idle();
      end
      repeat (60) @(posedge clock);

      $display("covered %0d samples under %0d register settings, %0d drive values checked",
               items_accepted, settings_count + 1, drives_checked);
      $display("mismatches: %0d", error_count);
      if (error_count == 0 && drive_expect_q.size() == 0)
         $display("clamped_pid_controller regression: pass");
      else
         $display("clamped_pid_controller regression: fail");
      $finish;
   end

endmodule

>>> sim.f
+incdir+src
src/cpid_pkg.sv
src/cpid_ctrl.sv
src/cpid_datapath.sv
src/clamped_pid_controller.sv
test/tb_clamped_pid_controller.sv
